### rtl/core/vdle_pkg.sv
// vdle_pkg: shared types, opcodes and constants for the vector display list executor.
// No dependencies; imported by every module in rtl/core.
package vdle_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int STACK_DEPTH_DEF   = 4;

  localparam int ADDR_W = 13;
  localparam int BEAM_W = 32;
  localparam int POS_W  = 17;
  localparam int SP_W   = 3;
  localparam int TINC_W = 5;

  // opcodes (first_word[15:12]); 0 through OP_LVEC_LAST are long vectors
  localparam logic [3:0] OP_LVEC_LAST = 4'h9;
  localparam logic [3:0] OP_LABS      = 4'ha;
  localparam logic [3:0] OP_HALT      = 4'hb;
  localparam logic [3:0] OP_CALL      = 4'hc;
  localparam logic [3:0] OP_RET       = 4'hd;
  localparam logic [3:0] OP_JUMP      = 4'he;
  localparam logic [3:0] OP_SVEC      = 4'hf;

  // register indexes on the APB port (byte address = 4 * index)
  localparam logic [1:0] REG_MIRROR  = 2'd0;
  localparam logic [1:0] REG_TEXDOT  = 2'd1;
  localparam logic [1:0] REG_YORIGIN = 2'd2;

  localparam logic [10:0]        Y_ORIGIN_RST    = 11'd1024;
  localparam logic signed [13:0] ABS_MIRROR_CTR  = 14'sd1024;
  localparam logic [3:0]         DOT_LINE_INTENS = 4'h4;
  localparam logic [3:0]         SVEC_MIN_INTENS = 4'h2;
  localparam logic [3:0]         SCALE_MAX       = 4'h9;
  localparam logic [3:0]         SHIFT_OVF       = 4'd10;
  localparam logic [3:0]         BRIGHT_LOW      = 4'hf;

  typedef enum logic [1:0] {
    DRAW_NONE     = 2'd0,
    DRAW_LINE     = 2'd1,
    DRAW_TEX_DOT  = 2'd2,
    DRAW_DOT_LINE = 2'd3
  } draw_kind_t;

  typedef struct packed {
    logic        exec;
    logic        restart;
    logic [3:0]  op;
    logic [11:0] target;
  } prog_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] fetch_address;
    logic              halted;
  } prog_stat_t;

  typedef struct packed {
    logic                     is_vec;
    logic signed [BEAM_W-1:0] dx;
    logic signed [BEAM_W-1:0] dy;
    draw_kind_t               kind;
    logic [7:0]               bright;
    logic signed [TINC_W-1:0] tinc;
  } vec_res_t;

endpackage

### rtl/core/vector_display_list_executor.sv
// vector_display_list_executor: top level; input register, beam and scale state,
// APB registers, result register. Depends on vdle_pkg, vdle_vec_calc, vdle_prog_ctrl.
//
// Usage:
//   in_*  : one display-list instruction per beat (restart flag and two words).
//   out_* : one result per instruction: draw kind on out_tuser, endpoints,
//           brightness, next fetch address, halt flag and time increment on tdata.
//   cfg_* : APB registers mirror_mode (0x0), textured_dots (0x4), y_origin (0x8);
//           write only while no instruction is in flight.
// An input beat is captured in the input register, then the instruction executes
// against the beam, scale and program state and the result lands in the output
// register. Throughput is one instruction per cycle while the output is not stalled,
// set by the single execute stage that updates state and fills the result register.
// When out_tready is low the result holds, the input register holds the next
// instruction and in_tready drops once both are full.
// Reset clears beam, scale, program address, stack pointer, registers (y_origin
// to 1024) and both valid flags; return stack entries are not cleared.
module vector_display_list_executor #(
  parameter int FRACTION_BITS = vdle_pkg::FRACTION_BITS_DEF,
  parameter int STACK_DEPTH   = vdle_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // restart[0], first_word[16:1], second_word[32:17]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // start_x[16:0], start_y[33:17], end_x[50:34],
                                  // end_y[67:51], brightness[75:68],
                                  // fetch_address[88:76], halted[89],
                                  // time_increment[94:90]
  output logic [1:0]  out_tuser,  // draw_kind[1:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import vdle_pkg::*;

  // config registers
  logic        mirror_r;
  logic        tex_r;
  logic [10:0] yorig_r;
  logic        cfg_wr;

  // input register
  logic        in_vld_r;
  logic        restart_r;
  logic [15:0] w1_r;
  logic [15:0] w2_r;

  // state
  logic signed [BEAM_W-1:0] bx_r, bx_nxt;
  logic signed [BEAM_W-1:0] by_r, by_nxt;
  logic [3:0]               gs_r, gs_nxt;

  // result register
  logic                     out_vld_r;
  draw_kind_t               kind_r;
  logic [POS_W-1:0]         sx_r, sy_r, ex_r, ey_r;
  logic [7:0]               bright_r;
  logic [ADDR_W-1:0]        fa_r;
  logic                     halted_r;
  logic signed [TINC_W-1:0] tinc_r;

  logic                     exec;
  logic signed [BEAM_W-1:0] bx_eff, by_eff;
  logic [3:0]               gs_eff;
  logic signed [BEAM_W-1:0] sx_w, sy_w, ex_w, ey_w;
  logic signed [13:0]       ax, ay;
  logic signed [13:0]       aby;
  vec_res_t                 vres;
  prog_cmd_t                pcmd;
  prog_stat_t               pstat;

  // APB
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= 1'b0;
      tex_r    <= 1'b0;
      yorig_r  <= Y_ORIGIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MIRROR:  mirror_r <= cfg_pwdata[0];
        REG_TEXDOT:  tex_r    <= cfg_pwdata[0];
        REG_YORIGIN: yorig_r  <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MIRROR:  cfg_prdata = {31'b0, mirror_r};
      REG_TEXDOT:  cfg_prdata = {31'b0, tex_r};
      REG_YORIGIN: cfg_prdata = {21'b0, yorig_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // handshake
  assign exec      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || exec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      restart_r <= in_tdata[0];
      w1_r      <= in_tdata[16:1];
      w2_r      <= in_tdata[32:17];
    end
  end

  // execute
  assign bx_eff = restart_r ? '0 : bx_r;
  assign by_eff = restart_r ? '0 : by_r;
  assign gs_eff = restart_r ? '0 : gs_r;

  vdle_vec_calc #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_vec_calc (
    .w1       (w1_r),
    .w2       (w2_r),
    .gscale   (gs_eff),
    .mirror   (mirror_r),
    .tex_dots (tex_r),
    .res      (vres)
  );

  assign pcmd.exec    = exec;
  assign pcmd.restart = restart_r;
  assign pcmd.op      = w1_r[15:12];
  assign pcmd.target  = w1_r[11:0];

  vdle_prog_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_prog_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (pcmd),
    .stat  (pstat)
  );

  always_comb begin
    ax  = mirror_r ? ABS_MIRROR_CTR - 14'($signed(w2_r[11:0]))
                   : 14'($signed(w2_r[11:0]));
    ay  = mirror_r ? ABS_MIRROR_CTR - 14'($signed(w1_r[11:0]))
                   : 14'($signed(w1_r[11:0]));
    aby = $signed({3'b000, yorig_r}) - ay;
  end

  always_comb begin
    bx_nxt = bx_eff;
    by_nxt = by_eff;
    gs_nxt = gs_eff;
    if (vres.is_vec) begin
      bx_nxt = bx_eff + vres.dx;
      by_nxt = by_eff - vres.dy;
    end else if (w1_r[15:12] == OP_LABS) begin
      bx_nxt = BEAM_W'(ax) <<< FRACTION_BITS;
      by_nxt = BEAM_W'(aby) <<< FRACTION_BITS;
      gs_nxt = w2_r[15:12];
    end
  end

  assign sx_w = bx_eff >>> FRACTION_BITS;
  assign sy_w = by_eff >>> FRACTION_BITS;
  assign ex_w = bx_nxt >>> FRACTION_BITS;
  assign ey_w = by_nxt >>> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_r <= '0;
      by_r <= '0;
      gs_r <= '0;
    end else if (exec) begin
      bx_r <= bx_nxt;
      by_r <= by_nxt;
      gs_r <= gs_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      kind_r   <= vres.kind;
      sx_r     <= sx_w[POS_W-1:0];
      sy_r     <= sy_w[POS_W-1:0];
      ex_r     <= ex_w[POS_W-1:0];
      ey_r     <= ey_w[POS_W-1:0];
      bright_r <= vres.bright;
      fa_r     <= pstat.fetch_address;
      halted_r <= pstat.halted;
      tinc_r   <= vres.tinc;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {1'b0, tinc_r, halted_r, fa_r, bright_r, ey_r, ex_r, sy_r, sx_r};

  // checks
  a_none_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == DRAW_NONE) |-> (out_tdata[75:68] == 8'h00))
    else $error("dark result carries brightness");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[89] |-> (out_tuser == DRAW_NONE) && (out_tdata[94:90] == 5'd0))
    else $error("halt result draws or adds time");

  a_addr_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[76] == 1'b0))
    else $error("odd fetch address");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_tready |-> !in_tready && !exec)
    else $error("input taken while both stages are full");

endmodule

### rtl/core/vdle_vec_calc.sv
// vdle_vec_calc: decodes long and short vector instructions into scaled beam deltas,
// draw kind, brightness and time increment. Combinational. Depends on vdle_pkg.
module vdle_vec_calc #(
  parameter int FRACTION_BITS = vdle_pkg::FRACTION_BITS_DEF
) (
  input  logic [15:0]        w1,
  input  logic [15:0]        w2,
  input  logic [3:0]         gscale,
  input  logic               mirror,
  input  logic               tex_dots,
  output vdle_pkg::vec_res_t res
);
  import vdle_pkg::*;

  logic [3:0]               op;
  logic                     is_long;
  logic [3:0]               z;
  logic [9:0]               mx_raw;
  logic [9:0]               my_raw;
  logic                     nx;
  logic                     ny;
  logic signed [10:0]       mag_x;
  logic signed [10:0]       mag_y;
  logic [3:0]               scale_raw;
  logic                     scale_ovf;
  logic [3:0]               shamt;
  logic signed [BEAM_W-1:0] sc_x;
  logic signed [BEAM_W-1:0] sc_y;
  logic signed [BEAM_W-1:0] dx;
  logic signed [BEAM_W-1:0] dy;
  logic                     draw;
  draw_kind_t               kind;

  assign op      = w1[15:12];
  assign is_long = (op <= OP_LVEC_LAST);

  always_comb begin
    if (is_long) begin
      z         = w2[15:12];
      my_raw    = w1[9:0];
      mx_raw    = w2[9:0];
      ny        = w1[10];
      nx        = w2[10];
      scale_raw = gscale + op;
      draw      = (z != 4'h0);
    end else begin
      z         = w1[7:4];
      my_raw    = {w1[9:8], 8'h00};
      mx_raw    = {w1[1:0], 8'h00};
      ny        = w1[10];
      nx        = w1[2];
      scale_raw = gscale + 4'd2 + {2'b00, w1[3], 1'b0} + {3'b000, w1[11]};
      draw      = (z > SVEC_MIN_INTENS);
    end
  end

  always_comb begin
    mag_x = (nx ^ mirror) ? -$signed({1'b0, mx_raw}) : $signed({1'b0, mx_raw});
    mag_y = (ny ^ mirror) ? -$signed({1'b0, my_raw}) : $signed({1'b0, my_raw});
  end

  assign scale_ovf = (scale_raw > SCALE_MAX);
  assign shamt     = scale_ovf ? SHIFT_OVF : (SCALE_MAX - scale_raw);

  assign sc_x = BEAM_W'(mag_x) <<< FRACTION_BITS;
  assign sc_y = BEAM_W'(mag_y) <<< FRACTION_BITS;
  assign dx   = sc_x >>> shamt;
  assign dy   = sc_y >>> shamt;

  always_comb begin
    kind = DRAW_NONE;
    if (draw) begin
      if (dx == '0 && dy == '0) begin
        if (z == DOT_LINE_INTENS) kind = DRAW_DOT_LINE;
        else if (is_long || tex_dots) kind = DRAW_TEX_DOT;
        else kind = DRAW_DOT_LINE;
      end else begin
        kind = DRAW_LINE;
      end
    end
  end

  always_comb begin
    res.is_vec = is_long || (op == OP_SVEC);
    res.dx     = dx;
    res.dy     = dy;
    res.kind   = res.is_vec ? kind : DRAW_NONE;
    res.bright = (res.is_vec && draw) ? {z, BRIGHT_LOW} : 8'h00;
    if (!res.is_vec) res.tinc = '0;
    else if (scale_ovf) res.tinc = -TINC_W'(1);
    else res.tinc = TINC_W'(scale_raw);
  end

endmodule

### rtl/core/vdle_prog_ctrl.sv
// vdle_prog_ctrl: program address, stack pointer and return stack; handles
// halt, call, return, jump and address advance. Depends on vdle_pkg.
module vdle_prog_ctrl #(
  parameter int STACK_DEPTH = vdle_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vdle_pkg::prog_cmd_t  cmd,
  output vdle_pkg::prog_stat_t stat
);
  import vdle_pkg::*;

  localparam int SP_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [ADDR_W-1:0] stack_mem [STACK_DEPTH];

  logic [ADDR_W-1:0] pc_base;
  logic [SP_W-1:0]   sp_base;
  logic [SP_W-1:0]   sp_dec;
  logic [ADDR_W-1:0] pc_seq;
  logic [ADDR_W-1:0] pc_target;
  logic              push;
  logic              halted;

  assign pc_base   = cmd.restart ? '0 : pc_r;
  assign sp_base   = cmd.restart ? '0 : sp_r;
  assign sp_dec    = sp_base - SP_W'(1);
  assign pc_seq    = pc_base + ((cmd.op < OP_HALT) ? ADDR_W'(4) : ADDR_W'(2));
  assign pc_target = {cmd.target, 1'b0};

  always_comb begin
    pc_nxt = pc_seq;
    sp_nxt = sp_base;
    push   = 1'b0;
    halted = 1'b0;
    unique case (cmd.op)
      OP_HALT: halted = 1'b1;
      OP_CALL: begin
        if ({1'b0, sp_base} >= 4'(STACK_DEPTH)) begin
          halted = 1'b1;
          sp_nxt = '0;
        end else begin
          push   = 1'b1;
          sp_nxt = sp_base + SP_W'(1);
          pc_nxt = pc_target;
        end
      end
      OP_RET: begin
        sp_nxt = sp_dec;
        pc_nxt = ({1'b0, sp_dec} < 4'(STACK_DEPTH)) ? stack_mem[sp_dec[SP_IDX_W-1:0]] : '0;
      end
      OP_JUMP: pc_nxt = pc_target;
      default: pc_nxt = pc_seq;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      sp_r <= '0;
    end else if (cmd.exec) begin
      pc_r <= pc_nxt;
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push) begin
      stack_mem[sp_base[SP_IDX_W-1:0]] <= pc_seq;
    end
  end

  assign stat.fetch_address = pc_nxt;
  assign stat.halted        = halted;

endmodule
